/* hdl/fhc_pkg.sv */
// Shared types and constants for the four-channel fade and hold controller.
// Used by fhc_step, four_channel_fade_hold_controller_core, the result checker and the testbench; no dependencies.
`default_nettype none

package fhc_pkg;

	// Field widths and channel count.
	localparam int NUM_CH         = 4;
	localparam int LEVEL_W        = 8;
	localparam int HOLD_W         = 12;
	localparam int CMD_W          = 2;
	localparam int MODE_W         = 2;
	localparam int HOLD_SCALE_DEF = 10;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RAMP = 2'd2;

	// Mode codes; the fourth code is never entered.
	localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FADING  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HOLDING = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;

	typedef logic [LEVEL_W-1:0] level_t;
	typedef level_t [NUM_CH-1:0] level_vec_t;
	typedef logic [HOLD_W-1:0] hold_t;

	// Complete controller state.
	typedef struct packed {
		level_vec_t          cur;
		level_vec_t          tgt;
		level_t              fade_reload;
		hold_t               hold_reload;
		hold_t               tick_cnt;
		logic [MODE_W-1:0]   mode;
	} fhc_state_t;

	// One input word as held in the input register.
	typedef struct packed {
		logic [CMD_W-1:0] command;
		level_vec_t       levels;
		level_t           fade_ticks;
		level_t           hold_units;
	} fhc_word_t;

endpackage

`default_nettype wire

/* hdl/fhc_step.sv */
// Next-state logic of the fade and hold controller for one input word.
// Depends on fhc_pkg for the state and word types and the command and mode codes.
`default_nettype none

module fhc_step
	import fhc_pkg::*;
#(
	parameter int HOLD_SCALE = HOLD_SCALE_DEF
) (
	input  fhc_state_t st,
	input  fhc_word_t  word,
	output fhc_state_t st_next,
	output logic       refused
);

	localparam int SCALE_W = $clog2(HOLD_SCALE + 1);
	localparam int PROD_W  = LEVEL_W + SCALE_W;

	logic [PROD_W-1:0]  hold_prod;
	level_vec_t         stepped;
	logic [NUM_CH-1:0]  matched;
	fhc_state_t         tick_st;
	hold_t              cnt_mid;

	// Hold time in ticks, kept to the counter width.
	assign hold_prod = PROD_W'(word.hold_units) * PROD_W'(HOLD_SCALE);

	// Each channel moves one count toward its target.
	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			matched[ch] = (st.cur[ch] == st.tgt[ch]);
			if (st.cur[ch] < st.tgt[ch]) begin
				stepped[ch] = st.cur[ch] + 1'b1;
			end else if (st.cur[ch] > st.tgt[ch]) begin
				stepped[ch] = st.cur[ch] - 1'b1;
			end else begin
				stepped[ch] = st.cur[ch];
			end
		end
	end

	// Tick: fade step or end of hold when the counter has run out, then count down.
	always_comb begin
		tick_st = st;
		cnt_mid = st.tick_cnt;
		if (st.mode == MODE_FADING && st.tick_cnt == '0) begin
			tick_st.cur = stepped;
			if (&matched) begin
				cnt_mid      = st.hold_reload;
				tick_st.mode = MODE_HOLDING;
			end else begin
				cnt_mid = HOLD_W'(st.fade_reload);
			end
		end else if (st.mode == MODE_HOLDING && st.tick_cnt == '0) begin
			tick_st.mode = MODE_OFF;
		end
		tick_st.tick_cnt = (cnt_mid != '0) ? cnt_mid - 1'b1 : cnt_mid;
	end

	// Command decode.
	always_comb begin
		st_next = st;
		refused = 1'b0;
		unique case (word.command)
			CMD_TICK: begin
				st_next = tick_st;
			end
			CMD_SET: begin
				st_next.mode = MODE_OFF;
				st_next.cur  = word.levels;
			end
			CMD_RAMP: begin
				if (st.mode != MODE_OFF) begin
					refused = 1'b1;
				end else begin
					st_next.tgt         = word.levels;
					st_next.fade_reload = word.fade_ticks;
					st_next.hold_reload = HOLD_W'(hold_prod);
					st_next.tick_cnt    = HOLD_W'(word.fade_ticks);
					st_next.mode        = MODE_FADING;
				end
			end
			default: begin
				st_next = st;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hdl/four_channel_fade_hold_controller_core.sv */
// Four-channel fade and hold controller: input register, state, result register.
// Depends on fhc_pkg and fhc_step.
//
// Each input word is a tick, a set of the four duty levels, or a ramp start, and
// gives exactly one result word with the four duty levels after it, the busy flag
// and a flag that a ramp was refused because the block was busy. The block takes
// one word every clock cycle while the result side does not stall. A result word is
// presented once its input word has passed the input register and the state update
// has loaded the result register; a stall on the result side holds the word in the
// input register. The rate is set by the update of the controller state from the
// registered word, which also loads the result register. Either side may stall at
// any time; the input register keeps taking words while the result register is emptied.
`default_nettype none

module four_channel_fade_hold_controller_core
	import fhc_pkg::*;
#(
	parameter int HOLD_SCALE = HOLD_SCALE_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [CMD_W-1:0]   command,
	input  wire logic [LEVEL_W-1:0] level_a,
	input  wire logic [LEVEL_W-1:0] level_b,
	input  wire logic [LEVEL_W-1:0] level_c,
	input  wire logic [LEVEL_W-1:0] level_d,
	input  wire logic [LEVEL_W-1:0] fade_ticks,
	input  wire logic [LEVEL_W-1:0] hold_units,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [LEVEL_W-1:0]      duty_a,
	output logic [LEVEL_W-1:0]      duty_b,
	output logic [LEVEL_W-1:0]      duty_c,
	output logic [LEVEL_W-1:0]      duty_d,
	output logic                    busy_res,
	output logic                    ramp_refused
);

	logic       valid_s1;
	fhc_word_t  word_s1;
	logic       advance;
	logic       in_take;
	fhc_state_t state_q;
	fhc_state_t state_next;
	logic       refused_next;
	logic       out_valid_q;
	level_vec_t duty_q;
	logic       busy_q;
	logic       refused_q;

	// Handshake: the registered word advances when the result register is free.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_take) begin
			word_s1.command    <= command;
			word_s1.levels[0]  <= level_a;
			word_s1.levels[1]  <= level_b;
			word_s1.levels[2]  <= level_c;
			word_s1.levels[3]  <= level_d;
			word_s1.fade_ticks <= fade_ticks;
			word_s1.hold_units <= hold_units;
		end
	end

	// State update for the registered word.
	fhc_step #(
		.HOLD_SCALE(HOLD_SCALE)
	) u_step (
		.st      (state_q),
		.word    (word_s1),
		.st_next (state_next),
		.refused (refused_next)
	);

	// Controller state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			duty_q    <= state_next.cur;
			busy_q    <= (state_next.mode != MODE_OFF);
			refused_q <= refused_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign duty_a       = duty_q[0];
	assign duty_b       = duty_q[1];
	assign duty_c       = duty_q[2];
	assign duty_d       = duty_q[3];
	assign busy_res     = busy_q;
	assign ramp_refused = refused_q;

	// A refused ramp is only ever reported while the block is busy.
	a_refused_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!ramp_refused || busy_res))
		else $error("ramp refused while not busy");

	// The spare mode code is never entered.
	a_no_spare_mode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode != MODE_SPARE)
		else $error("controller entered the spare mode");

	// An empty result register never holds back the input side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with an empty result register");

	// The state moves only when a word advances into the result register.
	a_state_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("controller state changed without a word");

endmodule

`default_nettype wire

/* bench/fhc_result_checker.sv */
// Result checker for the four-channel fade and hold controller testbench.
// Watches both channels, predicts each result word and compares it; needs fhc_pkg.
`timescale 1ns / 100ps

module fhc_result_checker
	import fhc_pkg::*;
#(
	parameter int HOLD_SCALE = HOLD_SCALE_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic [CMD_W-1:0]   command,
	input  wire logic [LEVEL_W-1:0] level_a,
	input  wire logic [LEVEL_W-1:0] level_b,
	input  wire logic [LEVEL_W-1:0] level_c,
	input  wire logic [LEVEL_W-1:0] level_d,
	input  wire logic [LEVEL_W-1:0] fade_ticks,
	input  wire logic [LEVEL_W-1:0] hold_units,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic [LEVEL_W-1:0] duty_a,
	input  wire logic [LEVEL_W-1:0] duty_b,
	input  wire logic [LEVEL_W-1:0] duty_c,
	input  wire logic [LEVEL_W-1:0] duty_d,
	input  wire logic               busy_res,
	input  wire logic               ramp_refused,
	output int                      mismatches,
	output int                      words_outstanding
);

	// One result word as the block should report it.
	typedef struct packed {
		level_vec_t duty;
		logic       busy;
		logic       refused;
	} duty_report_t;

	// Predicted controller state.
	level_vec_t          cur_level;
	level_vec_t          goal_level;
	level_t              fade_reload;
	hold_t               hold_reload;
	hold_t               tick_cnt;
	logic [MODE_W-1:0]   mode;
	duty_report_t        expected_reports[$];

	// Apply one input word to the predicted state and form its result word.
	task automatic step_controller(input logic [CMD_W-1:0] cmd, input level_vec_t lv,
			input level_t fade, input level_t hold, output duty_report_t rep);
		int   matched;
		int   ch;
		logic refused;
		refused = 1'b0;
		case (cmd)
			CMD_TICK: begin
				if (mode == MODE_FADING) begin
					if (tick_cnt == '0) begin
						matched = 0;
						for (ch = 0; ch < NUM_CH; ch++) begin
							if (cur_level[ch] < goal_level[ch])
								cur_level[ch] = cur_level[ch] + 1'b1;
							else if (cur_level[ch] > goal_level[ch])
								cur_level[ch] = cur_level[ch] - 1'b1;
							else
								matched++;
						end
						// Every channel already on target: start the hold period.
						if (matched == NUM_CH) begin
							tick_cnt = hold_reload;
							mode = MODE_HOLDING;
						end else begin
							tick_cnt = hold_t'(fade_reload);
						end
					end
				end else if (mode == MODE_HOLDING && tick_cnt == '0) begin
					mode = MODE_OFF;
				end
				if (tick_cnt != '0)
					tick_cnt = tick_cnt - 1'b1;
			end
			CMD_SET: begin
				// Forced levels stop any fade or hold; the counter keeps its value.
				mode = MODE_OFF;
				cur_level = lv;
			end
			CMD_RAMP: begin
				if (mode != MODE_OFF) begin
					refused = 1'b1;
				end else begin
					goal_level = lv;
					fade_reload = fade;
					hold_reload = hold_t'(HOLD_SCALE * int'(hold));
					tick_cnt = hold_t'(fade);
					mode = MODE_FADING;
				end
			end
			default: begin
			end
		endcase
		rep.duty = cur_level;
		rep.busy = (mode != MODE_OFF);
		rep.refused = refused;
	endtask

	// Pop and compare on each accepted result word, then predict each accepted input word.
	always @(posedge clk or negedge arst_n) begin : watch
		duty_report_t want;
		duty_report_t seen;
		int           n_bad;
		if (!arst_n) begin
			cur_level <= '0;
			goal_level <= '0;
			fade_reload <= '0;
			hold_reload <= '0;
			tick_cnt <= '0;
			mode <= MODE_OFF;
			expected_reports.delete();
			mismatches <= 0;
			words_outstanding <= 0;
		end else begin
			n_bad = 0;
			if (out_valid && out_ready) begin
				seen.duty = {duty_d, duty_c, duty_b, duty_a};
				seen.busy = busy_res;
				seen.refused = ramp_refused;
				if (expected_reports.size() == 0) begin
					n_bad = 1;
					if (mismatches < 10)
						$display("%0t: result word with none expected: duty %h %h %h %h busy %b refused %b",
							$realtime, duty_a, duty_b, duty_c, duty_d, busy_res, ramp_refused);
				end else begin
					want = expected_reports.pop_front();
					if (want !== seen) begin
						n_bad = 1;
						if (mismatches < 10)
							$display({"%0t: mismatch: expected duty %h %h %h %h busy %b refused %b,",
								" got duty %h %h %h %h busy %b refused %b"}, $realtime,
								want.duty[0], want.duty[1], want.duty[2], want.duty[3],
								want.busy, want.refused,
								seen.duty[0], seen.duty[1], seen.duty[2], seen.duty[3],
								seen.busy, seen.refused);
					end
				end
			end
			if (in_valid && in_ready) begin
				step_controller(command, {level_d, level_c, level_b, level_a},
					fade_ticks, hold_units, want);
				expected_reports.push_back(want);
			end
			mismatches <= mismatches + n_bad;
			words_outstanding <= expected_reports.size();
		end
	end

endmodule

/* bench/four_channel_fade_hold_controller_core_tb.sv */
// Testbench top for four_channel_fade_hold_controller_core: clock, reset, stimulus, verdict.
// Depends on fhc_pkg, the block itself and fhc_result_checker.
`timescale 1ns / 100ps

module four_channel_fade_hold_controller_core_tb;
	import fhc_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 1950;
	localparam int CYCLE_LIMIT = 400000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [CMD_W-1:0]   command;
	logic [LEVEL_W-1:0] level_a;
	logic [LEVEL_W-1:0] level_b;
	logic [LEVEL_W-1:0] level_c;
	logic [LEVEL_W-1:0] level_d;
	logic [LEVEL_W-1:0] fade_ticks;
	logic [LEVEL_W-1:0] hold_units;
	logic               out_valid;
	logic               out_ready;
	logic [LEVEL_W-1:0] duty_a;
	logic [LEVEL_W-1:0] duty_b;
	logic [LEVEL_W-1:0] duty_c;
	logic [LEVEL_W-1:0] duty_d;
	logic               busy_res;
	logic               ramp_refused;
	int                 mismatches;
	int                 words_outstanding;
	int                 cycles;
	int                 words_sent;
	logic               calm;

	four_channel_fade_hold_controller_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.level_a      (level_a),
		.level_b      (level_b),
		.level_c      (level_c),
		.level_d      (level_d),
		.fade_ticks   (fade_ticks),
		.hold_units   (hold_units),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.duty_a       (duty_a),
		.duty_b       (duty_b),
		.duty_c       (duty_c),
		.duty_d       (duty_d),
		.busy_res     (busy_res),
		.ramp_refused (ramp_refused)
	);

	fhc_result_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.command           (command),
		.level_a           (level_a),
		.level_b           (level_b),
		.level_c           (level_c),
		.level_d           (level_d),
		.fade_ticks        (fade_ticks),
		.hold_units        (hold_units),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.duty_a            (duty_a),
		.duty_b            (duty_b),
		.duty_c            (duty_c),
		.duty_d            (duty_d),
		.busy_res          (busy_res),
		.ramp_refused      (ramp_refused),
		.mismatches        (mismatches),
		.words_outstanding (words_outstanding)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side stalls at random except during the calm stretch.
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 29);
	end

	// Cycle count and the run's time limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Present one input word after an optional random gap and wait until it is taken.
	task automatic send_word(input logic [CMD_W-1:0] cmd, input level_vec_t lv,
			input level_t fade, input level_t hold);
		while (!calm && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		level_a <= lv[0];
		level_b <= lv[1];
		level_c <= lv[2];
		level_d <= lv[3];
		fade_ticks <= fade;
		hold_units <= hold;
		do
			@(posedge clk);
		while (!in_ready);
		if (cmd != CMD_UNUSED)
			words_sent++;
	endtask

	// Stop sending and wait until every predicted result word has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (words_outstanding != 0);
	endtask

	// Level biased toward the two extremes.
	function automatic level_t pick_level();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return level_t'($urandom);
	endfunction

	// Set, then a ramp to nearby targets, then up to 120 ticks to fade, hold and turn off.
	// Occasionally the tick run is cut short or an extra word is slipped in.
	task automatic run_fade_sequence();
		level_vec_t start_lv;
		level_vec_t goal_lv;
		int         ch;
		int         v;
		int         spread;
		int         fade;
		int         hold;
		int         ticks;
		int         k;
		spread = 0;
		for (ch = 0; ch < NUM_CH; ch++) begin
			start_lv[ch] = pick_level();
			v = int'(start_lv[ch]) + $urandom_range(8) - 4;
			if (v < 0)
				v = 0;
			if (v > 255)
				v = 255;
			goal_lv[ch] = level_t'(v);
			v = (v > int'(start_lv[ch])) ? v - int'(start_lv[ch]) : int'(start_lv[ch]) - v;
			if (v > spread)
				spread = v;
		end
		fade = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(3);
		hold = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(4);
		ticks = (spread + 1) * (fade + 1) + hold * 10 + 1 + $urandom_range(3);
		if ($urandom_range(9) == 0)
			ticks = $urandom_range(ticks);
		if (ticks > 120)
			ticks = 120;
		send_word(CMD_SET, start_lv, level_t'($urandom), level_t'($urandom));
		send_word(CMD_RAMP, goal_lv, level_t'(fade), level_t'(hold));
		for (k = 0; k < ticks; k++) begin
			if ($urandom_range(99) < 8) begin
				case ($urandom_range(2))
					0: send_word(CMD_RAMP, level_vec_t'($urandom), level_t'($urandom),
						level_t'($urandom_range(3)));
					1: send_word(CMD_UNUSED, level_vec_t'($urandom), level_t'($urandom),
						level_t'($urandom));
					default: send_word(CMD_SET, level_vec_t'($urandom), level_t'($urandom),
						level_t'($urandom));
				endcase
			end
			send_word(CMD_TICK, level_vec_t'($urandom), level_t'($urandom), level_t'($urandom));
		end
	endtask

	// A short burst of words with every field fully random.
	task automatic run_noise();
		int n;
		int k;
		n = $urandom_range(8, 1);
		for (k = 0; k < n; k++)
			send_word(CMD_W'($urandom_range(3)), level_vec_t'($urandom), level_t'($urandom),
				level_t'($urandom));
	endtask

	// Stimulus and verdict.
	initial begin : stimulus
		int   base;
		logic paused;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_TICK;
		level_a = '0;
		level_b = '0;
		level_c = '0;
		level_d = '0;
		fade_ticks = '0;
		hold_units = '0;
		out_ready = 1'b0;
		calm = 1'b0;
		cycles = 0;
		words_sent = 0;
		paused = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: reset state, unused command, extreme levels, refusal,
		// abort by set, a short complete fade, and a ramp onto the current levels.
		send_word(CMD_TICK, '0, '0, '0);
		send_word(CMD_UNUSED, '1, '1, '1);
		send_word(CMD_SET, '1, '0, '0);
		send_word(CMD_SET, {8'h5A, 8'hA5, 8'hFF, 8'h00}, '0, '0);
		send_word(CMD_RAMP, {8'h01, 8'hFE, 8'hA5, 8'h5B}, '1, '1);
		send_word(CMD_RAMP, '0, '0, '0);
		send_word(CMD_TICK, '0, '0, '0);
		send_word(CMD_UNUSED, '0, '0, '0);
		send_word(CMD_SET, {8'h04, 8'h03, 8'h02, 8'h01}, '1, '1);
		send_word(CMD_RAMP, {8'h05, 8'h03, 8'h01, 8'h02}, '0, '0);
		repeat (4) send_word(CMD_TICK, '1, '1, '1);
		send_word(CMD_SET, '0, '0, '0);
		send_word(CMD_RAMP, '0, 8'd1, '0);
		repeat (3) send_word(CMD_TICK, '0, '0, '0);
		wait_drained();

		// Random part: mostly complete fade sequences, the rest noise.
		base = words_sent;
		while (words_sent < base + RANDOM_WORDS) begin
			calm <= (words_sent >= base + 800) && (words_sent < base + 1100);
			if (!paused && words_sent >= base + RANDOM_WORDS / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			if ($urandom_range(99) < 70)
				run_fade_sequence();
			else
				run_noise();
		end
		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && words_outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* four_channel_fade_hold_controller_core.f */
hdl/fhc_pkg.sv
hdl/fhc_step.sv
hdl/four_channel_fade_hold_controller_core.sv
bench/fhc_result_checker.sv
bench/four_channel_fade_hold_controller_core_tb.sv
